>>> src/svrf_pkg.sv
// Shared types and constants for the sprite video register file.
`timescale 1ns / 1ps
package svrf_pkg;

  localparam int unsigned NUM_SPRITES = 8;
  localparam int unsigned STACK_DEPTH = 4;
  localparam int unsigned IDX_W       = $clog2(NUM_SPRITES);
  localparam int unsigned STK_W       = $clog2(STACK_DEPTH);

  localparam int unsigned ADDR_W = 6;
  localparam int unsigned DATA_W = 16;
  localparam int unsigned COLL_W = 10;
  localparam int unsigned XW_W   = 11;
  localparam int unsigned YW_W   = 12;
  localparam int unsigned ATTR_W = 14;
  localparam int unsigned CLR_W  = 4;
  localparam int unsigned FRM_W  = 8;

  // access kinds
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // register map: sprite banks by addr[5:3], single registers by full offset
  localparam logic [2:0] BANK_X    = 3'd0;
  localparam logic [2:0] BANK_Y    = 3'd1;
  localparam logic [2:0] BANK_ATTR = 3'd2;
  localparam logic [2:0] BANK_COLL = 3'd3;

  localparam logic [ADDR_W-1:0] ADDR_HANDSHAKE = 6'h20;
  localparam logic [ADDR_W-1:0] ADDR_MODE      = 6'h21;
  localparam logic [ADDR_W-1:0] ADDR_STACK0    = 6'h28;
  localparam logic [ADDR_W-1:0] ADDR_STACK1    = 6'h29;
  localparam logic [ADDR_W-1:0] ADDR_STACK2    = 6'h2A;
  localparam logic [ADDR_W-1:0] ADDR_STACK3    = 6'h2B;
  localparam logic [ADDR_W-1:0] ADDR_BORDER    = 6'h2C;
  localparam logic [ADDR_W-1:0] ADDR_DELAY_COL = 6'h30;
  localparam logic [ADDR_W-1:0] ADDR_DELAY_ROW = 6'h31;
  localparam logic [ADDR_W-1:0] ADDR_INHIBIT   = 6'h32;

  // attribute grom-select bit is stored inverted
  localparam logic [ATTR_W-1:0] ATTR_INV_MASK = 14'h0800;

  typedef struct packed {
    logic wr_x;
    logic wr_y;
    logic wr_attr;
    logic wr_coll;
    logic rd_coll;
    logic set_hs;
    logic set_mode;
    logic clr_mode;
    logic wr_stack;
    logic wr_border;
    logic wr_delay_col;
    logic wr_delay_row;
    logic wr_inhibit;
  } access_dec_t;

endpackage

>>> src/svrf_decode.sv
// Address and command decode for one register access.
`timescale 1ns / 1ps
module svrf_decode (
  input  logic                         cmd,
  input  logic [svrf_pkg::ADDR_W-1:0]  reg_addr,
  output svrf_pkg::access_dec_t        dec
);
  import svrf_pkg::*;

  logic is_wr;

  assign is_wr = (cmd == CMD_WRITE);

  always_comb begin
    dec = '0;
    unique case (reg_addr[ADDR_W-1:3])
      BANK_X:    dec.wr_x    = is_wr;
      BANK_Y:    dec.wr_y    = is_wr;
      BANK_ATTR: dec.wr_attr = is_wr;
      BANK_COLL: begin
        dec.wr_coll = is_wr;
        dec.rd_coll = !is_wr;
      end
      default: begin
        unique case (reg_addr) inside
          ADDR_HANDSHAKE: dec.set_hs = is_wr;
          ADDR_MODE: begin
            dec.clr_mode = is_wr;
            dec.set_mode = !is_wr;
          end
          ADDR_STACK0, ADDR_STACK1, ADDR_STACK2, ADDR_STACK3: dec.wr_stack = is_wr;
          ADDR_BORDER:    dec.wr_border    = is_wr;
          ADDR_DELAY_COL: dec.wr_delay_col = is_wr;
          ADDR_DELAY_ROW: dec.wr_delay_row = is_wr;
          ADDR_INHIBIT:   dec.wr_inhibit   = is_wr;
          default: ;
        endcase
      end
    endcase
  end

endmodule

>>> src/svrf_regs.sv
// Register storage: sprite words, collision words, colors, framing and flags.
`timescale 1ns / 1ps
module svrf_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  svrf_pkg::access_dec_t        dec,
  input  logic [svrf_pkg::ADDR_W-1:0]  reg_addr,
  input  logic [svrf_pkg::DATA_W-1:0]  write_data,
  output logic [svrf_pkg::COLL_W-1:0]  read_data_next,
  output logic                         stack_mode_next,
  output logic                         handshake_next
);
  import svrf_pkg::*;

  logic [XW_W-1:0]   sprite_x_word    [NUM_SPRITES];
  logic [YW_W-1:0]   sprite_y_word    [NUM_SPRITES];
  logic [ATTR_W-1:0] sprite_attr_word [NUM_SPRITES];
  logic [COLL_W-1:0] collision_word   [NUM_SPRITES];
  logic [CLR_W-1:0]  stack_colors     [STACK_DEPTH];
  logic [CLR_W-1:0]  border_color;
  logic [FRM_W-1:0]  framing_bits;
  logic              stack_mode_flag;
  logic              handshake_flag;

  logic [IDX_W-1:0]  idx;
  logic [STK_W-1:0]  sidx;
  logic [COLL_W-1:0] coll_wr_val;

  assign idx  = reg_addr[IDX_W-1:0];
  assign sidx = reg_addr[STK_W-1:0];
  // own-sprite bit is never stored
  assign coll_wr_val = write_data[COLL_W-1:0] & ~(COLL_W'(1) << idx);

  always_comb begin
    read_data_next  = dec.rd_coll ? collision_word[idx] : '0;
    stack_mode_next = dec.set_mode ? 1'b1 : (dec.clr_mode ? 1'b0 : stack_mode_flag);
    handshake_next  = dec.set_hs | handshake_flag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SPRITES; i++) begin
        sprite_x_word[i]    <= '0;
        sprite_y_word[i]    <= '0;
        sprite_attr_word[i] <= '0;
        collision_word[i]   <= '0;
      end
      for (int j = 0; j < STACK_DEPTH; j++) begin
        stack_colors[j] <= '0;
      end
      border_color    <= '0;
      framing_bits    <= '0;
      stack_mode_flag <= 1'b0;
      handshake_flag  <= 1'b0;
    end else if (en) begin
      if (dec.wr_x)    sprite_x_word[idx]  <= write_data[XW_W-1:0];
      if (dec.wr_y)    sprite_y_word[idx]  <= write_data[YW_W-1:0];
      if (dec.wr_attr) sprite_attr_word[idx] <= write_data[ATTR_W-1:0] ^ ATTR_INV_MASK;
      if (dec.wr_coll) collision_word[idx] <= coll_wr_val;
      if (dec.wr_stack)  stack_colors[sidx] <= write_data[CLR_W-1:0];
      if (dec.wr_border) border_color       <= write_data[CLR_W-1:0];
      if (dec.wr_delay_col) framing_bits[2:0] <= write_data[2:0];
      if (dec.wr_delay_row) framing_bits[5:3] <= write_data[2:0];
      if (dec.wr_inhibit)   framing_bits[7:6] <= write_data[1:0];
      stack_mode_flag <= stack_mode_next;
      handshake_flag  <= handshake_next;
    end
  end

endmodule

>>> src/svrf_out.sv
// Result register with valid/ready handshake toward the receiver.
`timescale 1ns / 1ps
module svrf_out (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  logic [svrf_pkg::COLL_W-1:0]  read_data_in,
  input  logic                         stack_mode_in,
  input  logic                         handshake_in,
  output logic                         free,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [svrf_pkg::COLL_W-1:0]  read_data,
  output logic                         stack_mode_now,
  output logic                         handshake_now
);
  import svrf_pkg::*;

  // can take a new beat when empty or when the held one leaves this cycle
  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      read_data      <= read_data_in;
      stack_mode_now <= stack_mode_in;
      handshake_now  <= handshake_in;
    end
  end

endmodule

>>> src/sprite_video_register_file_unit.sv
// Top level of the sprite video register file.
//
// Bus-side register file for an eight-sprite video chip. Each input beat on
// (in_valid, in_ready) is one access: cmd 0 reads, cmd 1 writes write_data
// at reg_addr. Each access yields exactly one output beat on
// (out_valid, out_ready) with read_data (collision word for reads of 0x18..0x1F,
// else zero) and the color-stack mode and handshake flags as they stand
// after the access.
//
// An accepted beat is held in the input register, which feeds decode and
// register-file update into the result register that raises out_valid.
// Throughput is one access per cycle while out_ready stays high; it is set
// by the single result register, which advances the input stage.
//
// Reset clears every register of the file, both flags and both stage
// valids. When the receiver stalls, the result register holds, the input
// stage holds one more access, and in_ready drops until space frees up.
`timescale 1ns / 1ps
module sprite_video_register_file_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         cmd,
  input  logic [svrf_pkg::ADDR_W-1:0]  reg_addr,
  input  logic [svrf_pkg::DATA_W-1:0]  write_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [svrf_pkg::COLL_W-1:0]  read_data,
  output logic                         stack_mode_now,
  output logic                         handshake_now
);
  import svrf_pkg::*;

  logic               s_valid;
  logic               s_cmd;
  logic [ADDR_W-1:0]  s_addr;
  logic [DATA_W-1:0]  s_data;
  logic               out_free;
  logic               advance;
  access_dec_t        dec;
  logic [COLL_W-1:0]  rd_next;
  logic               mode_next;
  logic               hs_next;

  assign advance  = s_valid && out_free;
  assign in_ready = !s_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s_cmd  <= cmd;
      s_addr <= reg_addr;
      s_data <= write_data;
    end
  end

  svrf_decode u_decode (
    .cmd      (s_cmd),
    .reg_addr (s_addr),
    .dec      (dec)
  );

  svrf_regs u_regs (
    .clk             (clk),
    .rst             (rst),
    .en              (advance),
    .dec             (dec),
    .reg_addr        (s_addr),
    .write_data      (s_data),
    .read_data_next  (rd_next),
    .stack_mode_next (mode_next),
    .handshake_next  (hs_next)
  );

  svrf_out u_out (
    .clk            (clk),
    .rst            (rst),
    .load           (advance),
    .read_data_in   (rd_next),
    .stack_mode_in  (mode_next),
    .handshake_in   (hs_next),
    .free           (out_free),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .read_data      (read_data),
    .stack_mode_now (stack_mode_now),
    .handshake_now  (handshake_now)
  );

endmodule
